[rtl/core/ucc_pkg.sv]
`timescale 1ns / 1ps

package ucc_pkg;

   localparam int CountWidth = 16;
   localparam logic [15:0] CapacityReset = 16'hffff;

   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_END  = 1'b1;

   localparam logic [1:0] ST_SUCCESS   = 2'd0;
   localparam logic [1:0] ST_INVALID   = 2'd1;
   localparam logic [1:0] ST_TOO_SMALL = 2'd2;

   localparam logic [2:0] CLS_ANY  = 3'd0;
   localparam logic [2:0] CLS_E0   = 3'd1;
   localparam logic [2:0] CLS_ED   = 3'd2;
   localparam logic [2:0] CLS_F0   = 3'd3;
   localparam logic [2:0] CLS_F4   = 3'd4;

   typedef struct packed {
      logic       valid;
      logic       is_end;
      logic [7:0] data;
   } ucc_word_type;

   typedef struct packed {
      logic [1:0]            bytes_pending;
      logic [2:0]            second_class;
      logic [2:0]            point_size;
      logic [CountWidth-1:0] count;
      logic                  decided;
      logic [1:0]            decided_status;
   } ucc_state_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [CountWidth-1:0] length;
   } ucc_result_type;

endpackage

[rtl/core/ucc_scan.sv]
`timescale 1ns / 1ps

module ucc_scan import ucc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  ucc_word_type   word,
   input  logic [15:0]    capacity,
   output ucc_result_type result
);

   ucc_state_type state_ff;
   ucc_state_type state_in;

   always_comb begin
      ucc_state_type nx;
      logic [2:0]    size;
      logic          complete;
      logic          ok;
      logic [16:0]   sum;
      logic [7:0]    b;

      nx       = state_ff;
      size     = state_ff.point_size;
      complete = 1'b0;
      ok       = 1'b1;
      b        = word.data;
      sum      = 17'd0;

      if (!state_ff.decided) begin
         if (state_ff.bytes_pending == 2'd0) begin
            nx.second_class = CLS_ANY;
            if (b <= 8'h7f) begin
               size     = 3'd1;
               complete = 1'b1;
            end else if (b >= 8'hc2 && b <= 8'hdf) begin
               size             = 3'd2;
               nx.bytes_pending = 2'd1;
            end else if (b >= 8'he0 && b <= 8'hef) begin
               size             = 3'd3;
               nx.bytes_pending = 2'd2;
               if (b == 8'he0) begin
                  nx.second_class = CLS_E0;
               end else if (b == 8'hed) begin
                  nx.second_class = CLS_ED;
               end
            end else if (b >= 8'hf0 && b <= 8'hf4) begin
               size             = 3'd4;
               nx.bytes_pending = 2'd3;
               if (b == 8'hf0) begin
                  nx.second_class = CLS_F0;
               end else if (b == 8'hf4) begin
                  nx.second_class = CLS_F4;
               end
            end else begin
               ok = 1'b0;
            end
            nx.point_size = size;
         end else begin
            if ({1'b0, state_ff.bytes_pending} + 3'd1 == state_ff.point_size) begin
               unique case (state_ff.second_class)
                  CLS_E0:  ok = (b >= 8'ha0 && b <= 8'hbf);
                  CLS_ED:  ok = (b >= 8'h80 && b <= 8'h9f);
                  CLS_F0:  ok = (b >= 8'h90 && b <= 8'hbf);
                  CLS_F4:  ok = (b >= 8'h80 && b <= 8'h8f);
                  default: ok = (b >= 8'h80 && b <= 8'hbf);
               endcase
            end else begin
               ok = (b >= 8'h80 && b <= 8'hbf);
            end
            if (ok) begin
               nx.bytes_pending = state_ff.bytes_pending - 2'd1;
               complete         = (state_ff.bytes_pending == 2'd1);
            end else begin
               nx.bytes_pending = 2'd0;
            end
         end

         if (!ok) begin
            nx.decided        = 1'b1;
            nx.decided_status = ST_INVALID;
         end else if (complete) begin
            sum = {1'b0, state_ff.count} + {14'd0, size};
            if (sum > {1'b0, capacity}) begin
               nx.decided        = 1'b1;
               nx.decided_status = (state_ff.count == '0) ? ST_TOO_SMALL : ST_SUCCESS;
            end else begin
               nx.count = sum[15:0];
            end
         end
      end

      state_in = state_ff;
      if (word.valid) begin
         state_in = word.is_end ? '0 : nx;
      end
   end

   always_comb begin
      result.length = state_ff.count;
      if (state_ff.decided) begin
         result.status = state_ff.decided_status;
      end else if (state_ff.bytes_pending != 2'd0) begin
         result.status = ST_INVALID;
      end else begin
         result.status = ST_SUCCESS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/utf8_capacity_chunker_core.sv]
`timescale 1ns / 1ps

// Strict UTF-8 prefix chunker. Text bytes and a closing end word enter on the req channel, one
// word per cycle when the result side is not stalled; each text byte is registered and then
// checked and counted in the next cycle, and the end word loads the status and prefix length
// into an output register at the edge where it leaves the input register. An end word waits
// in the input register only while an earlier result is held by rsp_stall. The capacity
// register resets to 65535 and should be written only while no text is in flight.

module utf8_capacity_chunker_core import ucc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_prefix_length,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   logic           in_valid_ff;
   logic           in_valid_in;
   logic           in_type_ff;
   logic [7:0]     in_byte_ff;
   logic           out_valid_ff;
   logic           out_valid_in;
   ucc_result_type out_ff;
   logic [15:0]    capacity_ff;
   logic           out_free;
   logic           step_fire;
   logic           req_accept;
   ucc_word_type   word;
   ucc_result_type result;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign step_fire  = in_valid_ff && ((in_type_ff == REQ_BYTE) || out_free);
   assign req_stall  = in_valid_ff && !step_fire;
   assign req_accept = req_valid && !req_stall;

   assign word.valid  = step_fire;
   assign word.is_end = (in_type_ff == REQ_END);
   assign word.data   = in_byte_ff;

   ucc_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .word     (word),
      .capacity (capacity_ff),
      .result   (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step_fire && word.is_end) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         capacity_ff  <= CapacityReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_type_ff <= req_type;
         in_byte_ff <= req_data_byte;
      end
      if (step_fire && word.is_end) begin
         out_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_ff.status;
   assign rsp_prefix_length = out_ff.length;

endmodule
